// ===== rtl/psc_pkg.sv =====
// Package for the packet segmenter with weighted checksum.
// Holds the payload size constants and the item and result structs.
// Used by every module of the block; depends on nothing.
`default_nettype none

package psc_pkg;

	localparam int MaxPayload = 1024;
	localparam int PosW = $clog2(MaxPayload);
	localparam int LimitW = 11;
	localparam int CmpW = (PosW + 1 > LimitW) ? PosW + 1 : LimitW;
	localparam int IndexW = 10;
	localparam int CountW = 11;
	localparam int SumW = 32;
	localparam logic [LimitW-1:0] LimitReset = LimitW'(1024);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       message_last;
	} item_t;

	typedef struct packed {
		logic [7:0]        out_byte;
		logic [IndexW-1:0] byte_index;
		logic              packet_end;
		logic              packet_kind;
		logic [CountW-1:0] payload_count;
		logic [SumW-1:0]   packet_sum;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/packet_segmenter_checksum.sv =====
// Top level of the packet segmenter with swapped-index weighted checksum.
// Instantiates psc_in_reg and psc_core and holds the payload limit register.
// Depends on psc_pkg.
//
// Usage:
// Message bytes enter on the input channel (data_byte, message_last with
// in_valid/in_ready); one result per byte leaves on the output channel
// (out_valid/out_ready). Each result repeats the byte with its index in the
// packet; the byte that closes a packet also carries payload_count,
// packet_sum and packet_kind, which read as zero on other bytes.
// A packet closes on the message's final byte or when it reaches the
// payload limit, written through cfg_we/cfg_wdata. The user must write it
// only while the block is idle; the block itself does not enforce it.
// An accepted request is loaded into the input register and then, after a
// single multiply-accumulate, into the result register once that is free.
// Throughput is one byte per cycle while the receiver keeps taking results.
// When the receiver stalls, the result register holds and the input
// register still takes one more request; in_ready then drops until the
// result is taken.
// Reset clears both stages, the packet position and the running sum, and
// sets the payload limit to 1024.
`default_nettype none

module packet_segmenter_checksum (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [7:0]                         data_byte,
	input  wire logic                               message_last,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [7:0]                              out_byte,
	output logic [psc_pkg::IndexW-1:0]              byte_index,
	output logic                                    packet_end,
	output logic                                    packet_kind,
	output logic [psc_pkg::CountW-1:0]              payload_count,
	output logic [psc_pkg::SumW-1:0]                packet_sum,
	input  wire logic                               cfg_we,
	input  wire logic [psc_pkg::LimitW-1:0]         cfg_wdata
);

	logic [psc_pkg::LimitW-1:0] limit_q;
	psc_pkg::item_t             item_in;
	psc_pkg::item_t             item_s1;
	psc_pkg::result_t           res_s2;
	logic                       valid_s1;
	logic                       advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= psc_pkg::LimitReset;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	assign item_in.data_byte = data_byte;
	assign item_in.message_last = message_last;

	psc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item_in  (item_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	psc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.limit     (limit_q),
		.out_ready (out_ready),
		.advance   (advance),
		.valid_s2  (out_valid),
		.res_s2    (res_s2)
	);

	assign out_byte = res_s2.out_byte;
	assign byte_index = res_s2.byte_index;
	assign packet_end = res_s2.packet_end;
	assign packet_kind = res_s2.packet_kind;
	assign payload_count = res_s2.payload_count;
	assign packet_sum = res_s2.packet_sum;

endmodule

`default_nettype wire

// ===== rtl/psc_in_reg.sv =====
// Input register stage of the packet segmenter.
// Captures one request per cycle while the compute stage can advance.
// Depends on psc_pkg for the item struct.
`default_nettype none

module psc_in_reg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire psc_pkg::item_t  item_in,
	input  wire logic            advance,
	output logic                 valid_s1,
	output psc_pkg::item_t       item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_in;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/psc_core.sv =====
// Compute stage of the packet segmenter: position and running sum state,
// the weighted multiply-accumulate, and the result register.
// Depends on psc_pkg for constants and structs.
`default_nettype none

module psc_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          valid_s1,
	input  wire psc_pkg::item_t                item_s1,
	input  wire logic [psc_pkg::LimitW-1:0]    limit,
	input  wire logic                          out_ready,
	output logic                               advance,
	output logic                               valid_s2,
	output psc_pkg::result_t                   res_s2
);

	logic [psc_pkg::PosW-1:0] position_q;
	logic [psc_pkg::SumW-1:0] running_sum_q;
	logic [psc_pkg::CmpW-1:0] eff_limit;
	logic [psc_pkg::CmpW-1:0] limit_ext;
	logic [psc_pkg::CmpW-1:0] next_pos;
	logic                     closes;
	logic [psc_pkg::PosW-1:0] weight;
	logic [psc_pkg::SumW-1:0] product;
	logic [psc_pkg::SumW-1:0] sum;
	psc_pkg::result_t         res;

	assign advance = !valid_s2 || out_ready;

	always_comb begin
		limit_ext = psc_pkg::CmpW'(limit);
		if (limit_ext == '0) begin
			eff_limit = psc_pkg::CmpW'(1);
		end else if (limit_ext > psc_pkg::CmpW'(psc_pkg::MaxPayload)) begin
			eff_limit = psc_pkg::CmpW'(psc_pkg::MaxPayload);
		end else begin
			eff_limit = limit_ext;
		end
		next_pos = psc_pkg::CmpW'(position_q) + psc_pkg::CmpW'(1);
		closes = item_s1.message_last || (next_pos >= eff_limit);
		if (position_q[0]) begin
			weight = position_q - psc_pkg::PosW'(1);
		end else if (closes) begin
			weight = position_q;
		end else begin
			weight = position_q + psc_pkg::PosW'(1);
		end
		product = psc_pkg::SumW'(item_s1.data_byte) * psc_pkg::SumW'(weight);
		sum = running_sum_q + product;

		res.out_byte = item_s1.data_byte;
		res.byte_index = psc_pkg::IndexW'(position_q);
		res.packet_end = closes;
		res.packet_kind = closes && item_s1.message_last;
		res.payload_count = closes ? psc_pkg::CountW'(next_pos) : '0;
		res.packet_sum = closes ? sum : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			position_q <= '0;
			running_sum_q <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				if (closes) begin
					position_q <= '0;
					running_sum_q <= '0;
				end else begin
					position_q <= psc_pkg::PosW'(next_pos);
					running_sum_q <= sum;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/psc_checker.sv =====
// Port-level checker for the packet segmenter, with its bind statement.
// Watches the output channel of packet_segmenter_checksum; depends on psc_pkg.
`default_nettype none

module psc_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [7:0]                    out_byte,
	input wire logic [psc_pkg::IndexW-1:0]    byte_index,
	input wire logic                          packet_end,
	input wire logic                          packet_kind,
	input wire logic [psc_pkg::CountW-1:0]    payload_count,
	input wire logic [psc_pkg::SumW-1:0]      packet_sum
);

	logic prev_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_end_q <= 1'b1;
		end else if (out_valid && out_ready) begin
			prev_end_q <= packet_end;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte)
			&& $stable(byte_index) && $stable(packet_end) && $stable(packet_sum))
		else $error("Result changed while the receiver stalled.");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !packet_end |-> !packet_kind && payload_count == '0
			&& packet_sum == '0)
		else $error("Packet fields set on a byte that does not close a packet.");

	a_count_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && packet_end |->
			payload_count == psc_pkg::CountW'(byte_index) + psc_pkg::CountW'(1))
		else $error("Packet length does not match the closing byte index.");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && prev_end_q |-> byte_index == '0)
		else $error("New packet does not start at index zero.");

endmodule

bind packet_segmenter_checksum psc_checker u_psc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.out_byte      (out_byte),
	.byte_index    (byte_index),
	.packet_end    (packet_end),
	.packet_kind   (packet_kind),
	.payload_count (payload_count),
	.packet_sum    (packet_sum)
);

`default_nettype wire
